@@ rtl/i2cseq_pkg.sv @@
// ----------------------------------------------------------------------------
// I2C master sequencer package
// Item layouts, controller status codes and small helpers shared by the
// sequencer and its channel interfaces.
// ----------------------------------------------------------------------------
package i2cseq_pkg;

	// Command item, one per transfer on the command channel.
	typedef struct packed {
		logic [1:0] mode;
		logic [2:0] kind;
		logic [7:0] slave_addr;
		logic [5:0] first_len;
		logic [5:0] second_len;
		logic [4:0] buf_index;
		logic [7:0] data_byte;
		logic [7:0] status_code;
	} cmd_t;

	// Action item, one per transfer on the action channel.
	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       set_start;
		logic       set_stop;
		logic [1:0] ack_ctrl;
		logic       clear_start;
		logic [2:0] master_state;
		logic       busy_res;
		logic       buffer_in_use;
		logic       rx_valid;
		logic [4:0] rx_index;
		logic [7:0] rx_byte;
	} act_t;

	// Command modes.
	localparam logic [1:0] MODE_LOAD    = 2'd0;
	localparam logic [1:0] MODE_START   = 2'd1;
	localparam logic [1:0] MODE_EVENT   = 2'd2;
	localparam logic [1:0] MODE_RELEASE = 2'd3;

	// Transaction kinds.
	localparam logic [2:0] KIND_RD_SINGLE = 3'd0;
	localparam logic [2:0] KIND_RD_BLOCK  = 3'd1;
	localparam logic [2:0] KIND_WR_SINGLE = 3'd2;
	localparam logic [2:0] KIND_WR_BLOCK  = 3'd3;
	localparam logic [2:0] KIND_WR_RD     = 3'd4;

	// Controller status codes.
	localparam logic [7:0] SC_START       = 8'h08;
	localparam logic [7:0] SC_RSTART      = 8'h10;
	localparam logic [7:0] SC_SLA_W_ACK   = 8'h18;
	localparam logic [7:0] SC_SLA_W_NACK  = 8'h20;
	localparam logic [7:0] SC_DATA_TX_ACK = 8'h28;
	localparam logic [7:0] SC_DATA_TX_NAK = 8'h30;
	localparam logic [7:0] SC_SLA_R_ACK   = 8'h40;
	localparam logic [7:0] SC_SLA_R_NACK  = 8'h48;
	localparam logic [7:0] SC_DATA_RX_ACK = 8'h50;
	localparam logic [7:0] SC_DATA_RX_NAK = 8'h58;

	// Direction bit handling on the address byte.
	localparam logic [7:0] ADDR_READ_BIT   = 8'h01;
	localparam logic [7:0] ADDR_WRITE_MASK = 8'hFE;

	// Reported master state.
	localparam logic [2:0] MST_IDLE   = 3'd0;
	localparam logic [2:0] MST_NACK   = 3'd1;
	localparam logic [2:0] MST_DONE   = 3'd2;
	localparam logic [2:0] MST_RSTART = 3'd3;
	localparam logic [2:0] MST_DACK   = 3'd4;
	localparam logic [2:0] MST_ERROR  = 3'd5;

	// Acknowledge control.
	localparam logic [1:0] ACK_NONE = 2'd0;
	localparam logic [1:0] ACK_SET  = 2'd1;
	localparam logic [1:0] ACK_CLR  = 2'd2;

	localparam logic [5:0] PTR_MAX = 6'd63;

	// Pointer increment that saturates at the top of its range.
	function automatic logic [5:0] ptr_inc(input logic [5:0] p);
		return (p == PTR_MAX) ? PTR_MAX : p + 6'd1;
	endfunction

endpackage

@@ rtl/i2cseq_cmd_if.sv @@
// ----------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries command items into the sequencer.
// ----------------------------------------------------------------------------
interface i2cseq_cmd_if;
	logic               valid;
	logic               ready;
	i2cseq_pkg::cmd_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/i2cseq_act_if.sv @@
// ----------------------------------------------------------------------------
// Action channel
// Valid/ready channel that carries controller actions out of the sequencer.
// ----------------------------------------------------------------------------
interface i2cseq_act_if;
	logic               valid;
	logic               ready;
	i2cseq_pkg::act_t   data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/i2cseq_wstore.sv @@
// ----------------------------------------------------------------------------
// Write store
// Byte memory for block writes, one write port and one registered read port
// with write-to-read forwarding on a shared address.
// ----------------------------------------------------------------------------
module i2cseq_wstore #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [7:0]    wr_data,
	input  logic [AW-1:0] rd_addr,
	output logic [7:0]    rd_data
);
	logic [7:0] mem [DEPTH];
	logic [7:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// A write to the address being read is seen by the read in the same cycle.
	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == rd_addr)) begin
			rd_q <= wr_data;
		end else begin
			rd_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_q;
endmodule

@@ rtl/i2c_master_transaction_sequencer.sv @@
// ----------------------------------------------------------------------------
// I2C master transaction sequencer
// One channel of a status-code driven I2C master: turns commands and
// controller status events into the next controller actions.
// ----------------------------------------------------------------------------
// Usage. Commands arrive on the cmd channel: a load puts a byte into the
// write store, a start opens a transaction of one of five kinds, a status
// event reports the controller's status code with the received byte, and a
// release drops the buffer-claimed flag. Every command transfer produces
// exactly one action item on the act channel, in order.
// The action for a command is presented on act in the cycle after its
// transfer. Throughput is one command per cycle; the only limit is the
// single output register, so cmd.ready falls only while an action is
// held there and act.ready is low. A stalled receiver therefore
// holds the pending action unchanged and back-pressures the command side
// without losing anything.
// The write store is a memory read ahead at the next write pointer,
// so a data transmit never waits on the memory.
// Reset clears every control flag, counter and pointer and empties the
// output register; the write store is not cleared and must be loaded
// before its entries are sent.
// ----------------------------------------------------------------------------
module i2c_master_transaction_sequencer #(
	parameter int BUF_DEPTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	i2cseq_cmd_if.sink         cmd,
	i2cseq_act_if.source       act
);
	import i2cseq_pkg::*;

	localparam int AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;

	// Sequencer state.
	logic [7:0] addr_q,         addr_d;
	logic [5:0] write_count_q,  write_count_d;
	logic [5:0] read_count_q,   read_count_d;
	logic [5:0] write_ptr_q,    write_ptr_d;
	logic [5:0] read_ptr_q,     read_ptr_d;
	logic [7:0] single_q,       single_d;
	logic       block_q,        block_d;
	logic       wtr_q,          wtr_d;
	logic [2:0] state_code_q,   state_code_d;
	logic       busy_q,         busy_d;
	logic       buf_q,          buf_d;

	// Output register.
	logic       act_valid_q;
	act_t       act_q;
	act_t       act_d;

	logic       accept;
	cmd_t       c;
	logic       st_wr_en;
	logic [7:0] st_rd_data;
	logic [7:0] store_byte;
	logic [5:0] rp_inc;
	logic       l1_ok;
	logic       l2_ok;

	assign c      = cmd.data;
	assign cmd.ready = !act_valid_q || act.ready;
	assign accept = cmd.valid && cmd.ready;

	assign l1_ok = int'(c.first_len)  <= BUF_DEPTH;
	assign l2_ok = int'(c.second_len) <= BUF_DEPTH;

	// The store read port always tracks the write pointer the next item will
	// see, so its registered data lines up with write_ptr_q.
	assign st_wr_en = accept && (c.mode == MODE_LOAD) && (int'(c.buf_index) < BUF_DEPTH);

	i2cseq_wstore #(
		.DEPTH (BUF_DEPTH),
		.AW    (AW)
	) u_wstore (
		.clk     (clk),
		.wr_en   (st_wr_en),
		.wr_addr (AW'(c.buf_index)),
		.wr_data (c.data_byte),
		.rd_addr (AW'(write_ptr_d)),
		.rd_data (st_rd_data)
	);

	// Pointers past the end of the store send a zero byte.
	assign store_byte = (int'(write_ptr_q) < BUF_DEPTH) ? st_rd_data : 8'h00;
	assign rp_inc     = ptr_inc(read_ptr_q);

	// Next state and action for the item at the command port.
	always_comb begin
		addr_d        = addr_q;
		write_count_d = write_count_q;
		read_count_d  = read_count_q;
		write_ptr_d   = write_ptr_q;
		read_ptr_d    = read_ptr_q;
		single_d      = single_q;
		block_d       = block_q;
		wtr_d         = wtr_q;
		state_code_d  = state_code_q;
		busy_d        = busy_q;
		buf_d         = buf_q;
		act_d         = '0;

		if (accept) begin
			case (c.mode)
				MODE_LOAD: begin
					// Handled entirely by the store write port.
				end
				MODE_START: begin
					case (c.kind)
						KIND_RD_SINGLE: begin
							wtr_d           = 1'b0;
							read_count_d    = 6'd0;
							addr_d          = c.slave_addr | ADDR_READ_BIT;
							block_d         = 1'b0;
							state_code_d    = MST_IDLE;
							busy_d          = 1'b1;
							act_d.set_start = 1'b1;
						end
						KIND_RD_BLOCK: begin
							if (l1_ok) begin
								wtr_d           = 1'b0;
								read_count_d    = c.first_len;
								read_ptr_d      = 6'd0;
								addr_d          = c.slave_addr | ADDR_READ_BIT;
								block_d         = 1'b1;
								state_code_d    = MST_IDLE;
								busy_d          = 1'b1;
								buf_d           = 1'b1;
								act_d.set_start = 1'b1;
							end
						end
						KIND_WR_SINGLE: begin
							wtr_d           = 1'b0;
							write_count_d   = 6'd0;
							write_ptr_d     = 6'd0;
							single_d        = c.data_byte;
							addr_d          = c.slave_addr & ADDR_WRITE_MASK;
							block_d         = 1'b0;
							state_code_d    = MST_IDLE;
							busy_d          = 1'b1;
							act_d.set_start = 1'b1;
						end
						KIND_WR_BLOCK: begin
							if (l1_ok) begin
								wtr_d           = 1'b0;
								write_count_d   = c.first_len;
								write_ptr_d     = 6'd0;
								addr_d          = c.slave_addr & ADDR_WRITE_MASK;
								block_d         = 1'b1;
								state_code_d    = MST_IDLE;
								busy_d          = 1'b1;
								buf_d           = 1'b1;
								act_d.set_start = 1'b1;
							end
						end
						KIND_WR_RD: begin
							if (l1_ok && l2_ok) begin
								wtr_d           = 1'b1;
								write_count_d   = c.first_len;
								read_count_d    = c.second_len;
								write_ptr_d     = 6'd0;
								read_ptr_d      = 6'd0;
								addr_d          = c.slave_addr & ADDR_WRITE_MASK;
								block_d         = 1'b1;
								state_code_d    = MST_IDLE;
								busy_d          = 1'b1;
								buf_d           = 1'b1;
								act_d.set_start = 1'b1;
							end
						end
						default: begin
							// Unknown kinds are ignored.
						end
					endcase
				end
				MODE_EVENT: begin
					case (c.status_code)
						SC_START: begin
							act_d.tx_valid    = 1'b1;
							act_d.tx_byte     = addr_q;
							act_d.clear_start = 1'b1;
						end
						SC_RSTART: begin
							// Only the read phase of a write-then-read uses a
							// repeated start; it resends the address for reading.
							if (wtr_q) begin
								act_d.tx_valid    = 1'b1;
								act_d.tx_byte     = addr_q | ADDR_READ_BIT;
								act_d.clear_start = 1'b1;
							end
						end
						SC_SLA_W_ACK: begin
							act_d.tx_valid = 1'b1;
							act_d.ack_ctrl = ACK_SET;
							if (block_q) begin
								act_d.tx_byte = store_byte;
								write_ptr_d   = ptr_inc(write_ptr_q);
							end else begin
								act_d.tx_byte = single_q;
							end
						end
						SC_SLA_W_NACK, SC_DATA_TX_NAK: begin
							state_code_d   = MST_NACK;
							act_d.set_stop = 1'b1;
							act_d.ack_ctrl = ACK_SET;
							busy_d         = 1'b0;
						end
						SC_DATA_TX_ACK: begin
							if (block_q && (write_ptr_q < write_count_q)) begin
								act_d.tx_valid = 1'b1;
								act_d.tx_byte  = store_byte;
								act_d.ack_ctrl = ACK_SET;
								write_ptr_d    = ptr_inc(write_ptr_q);
							end else if (block_q && wtr_q) begin
								act_d.set_start = 1'b1;
								state_code_d    = MST_RSTART;
							end else begin
								state_code_d   = MST_DONE;
								act_d.set_stop = 1'b1;
								act_d.ack_ctrl = ACK_SET;
								busy_d         = 1'b0;
							end
						end
						SC_SLA_R_ACK: begin
							act_d.ack_ctrl = ACK_SET;
						end
						SC_DATA_RX_ACK: begin
							if (block_q) begin
								if (int'(read_ptr_q) < BUF_DEPTH) begin
									act_d.rx_valid = 1'b1;
									act_d.rx_index = read_ptr_q[4:0];
									act_d.rx_byte  = c.data_byte;
								end
								read_ptr_d = rp_inc;
								if (rp_inc >= read_count_q) begin
									state_code_d   = MST_DONE;
									act_d.ack_ctrl = ACK_CLR;
								end else begin
									state_code_d   = MST_DACK;
									act_d.ack_ctrl = ACK_SET;
								end
							end else begin
								act_d.rx_valid = 1'b1;
								act_d.rx_byte  = c.data_byte;
								state_code_d   = MST_DONE;
								act_d.ack_ctrl = ACK_CLR;
								busy_d         = 1'b0;
							end
						end
						SC_DATA_RX_NAK: begin
							// Last byte not acknowledged: stop, state unchanged.
							busy_d         = 1'b0;
							act_d.set_stop = 1'b1;
						end
						SC_SLA_R_NACK: begin
							state_code_d   = MST_NACK;
							act_d.set_stop = 1'b1;
							busy_d         = 1'b0;
						end
						default: begin
							state_code_d = MST_ERROR;
						end
					endcase
				end
				MODE_RELEASE: begin
					buf_d = 1'b0;
				end
				default: begin
				end
			endcase
		end

		act_d.master_state  = state_code_d;
		act_d.busy_res      = busy_d;
		act_d.buffer_in_use = buf_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q        <= '0;
			write_count_q <= '0;
			read_count_q  <= '0;
			write_ptr_q   <= '0;
			read_ptr_q    <= '0;
			single_q      <= '0;
			block_q       <= 1'b0;
			wtr_q         <= 1'b0;
			state_code_q  <= MST_IDLE;
			busy_q        <= 1'b0;
			buf_q         <= 1'b0;
		end else if (accept) begin
			addr_q        <= addr_d;
			write_count_q <= write_count_d;
			read_count_q  <= read_count_d;
			write_ptr_q   <= write_ptr_d;
			read_ptr_q    <= read_ptr_d;
			single_q      <= single_d;
			block_q       <= block_d;
			wtr_q         <= wtr_d;
			state_code_q  <= state_code_d;
			busy_q        <= busy_d;
			buf_q         <= buf_d;
		end
	end

	// The output register fills on each command transfer and empties when
	// the receiver takes the action.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_valid_q <= 1'b0;
		end else if (accept) begin
			act_valid_q <= 1'b1;
		end else if (act.ready) begin
			act_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= act_d;
		end
	end

	assign act.valid = act_valid_q;
	assign act.data  = act_q;

	// A held action that is not taken must block any new command.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(act_valid_q && !act.ready) |-> !accept)
		else $error("command taken while an action is stalled");

	// The buffer can only become claimed through a start command.
	a_buf_claim: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(buf_q) |-> $past(accept && (c.mode == MODE_START)))
		else $error("buffer claimed outside a start");

	// Start and stop are never requested by the same action.
	a_start_stop: assert property (@(posedge clk) disable iff (!arst_n)
		act_valid_q |-> !(act_q.set_start && act_q.set_stop))
		else $error("start and stop requested together");

	// An accepted start that requests a start condition leaves the block busy.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (c.mode == MODE_START) && act_d.set_start) |=> busy_q)
		else $error("start accepted without setting busy");
endmodule
